// ===== hw/rtl/ltpr_pkg.sv =====
// ltpr_pkg: shared types, codes and defaults for the line table pc resolver
// no dependencies; used by every rtl file of the block but ltpr_fifo, and by its checker
package ltpr_pkg;

  // input operations
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  // result status codes
  localparam logic [1:0] ST_FOUND = 2'd0;
  localparam logic [1:0] ST_ENDED = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_SET_FILE   = 2'd0;
  localparam logic [1:0] REG_EXT_STEP   = 2'd1;
  localparam logic [1:0] REG_PROLOGUE   = 2'd2;
  localparam logic [1:0] REG_FILE_COUNT = 2'd3;

  localparam logic [7:0]  RST_SET_FILE   = 8'd255;
  localparam logic [7:0]  RST_EXT_STEP   = 8'd254;
  localparam logic [7:0]  RST_PROLOGUE   = 8'd253;
  localparam logic [15:0] RST_FILE_COUNT = 16'd0;

  localparam logic [7:0] VLQ_PAYLOAD_MASK = 8'h7F;
  localparam logic [5:0] VLQ_SHIFT_STEP   = 6'd7;
  localparam logic [5:0] VLQ_SHIFT_MAX    = 6'd35;
  localparam logic [5:0] VLQ_SHIFT_LIMIT  = 6'd32;

  // queue depths (powers of two, at least 2)
  localparam int CMD_DEPTH_DEF = 2;
  localparam int RES_DEPTH_DEF = 2;

  typedef struct packed {
    logic [7:0]  set_file_code;
    logic [7:0]  extended_step_code;
    logic [7:0]  prologue_end_code;
    logic [15:0] known_files;
  } cfg_t;

  // commands passed from the front decoder to the back walker
  typedef enum logic [2:0] {
    CMD_START     = 3'd0,
    CMD_SET_FILE  = 3'd1,
    CMD_STEP      = 3'd2,
    CMD_END       = 3'd3,
    CMD_END_STEP  = 3'd4,
    CMD_END_EMPTY = 3'd5
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [31:0] a;   // target pc, file index or pc delta
    logic [31:0] b;   // line delta
  } cmd_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [15:0]        file_idx;
    logic               unknown_file;
    logic signed [31:0] line_number;
  } res_t;

  // decoder phase, one-hot
  typedef enum logic [3:0] {
    PH_CMD   = 4'b0001,
    PH_FILE  = 4'b0010,
    PH_XPC   = 4'b0100,
    PH_XLINE = 4'b1000
  } phase_t;

  function automatic logic [31:0] unzigzag(input logic [31:0] u);
    unzigzag = (u >> 1) ^ {32{u[0]}};
  endfunction

endpackage

// ===== hw/rtl/ltpr_fifo.sv =====
// ltpr_fifo: small register queue with first-word fall-through read
// generic, no package dependency; DEPTH must be a power of two
module ltpr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty,
  output logic             full
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == CW'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + PW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== hw/rtl/ltpr_front.sv =====
// ltpr_front: decodes table bytes and vlq operands into walker commands
// depends on ltpr_pkg
module ltpr_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  logic [1:0]          op,
  input  logic [31:0]         target_pc,
  input  logic [7:0]          data_byte,
  input  ltpr_pkg::cfg_t      cfg,
  output logic                cmd_push,
  output ltpr_pkg::cmd_t      cmd
);
  ltpr_pkg::phase_t phase_r, phase_nxt;
  logic [31:0] accum_r, accum_nxt;
  logic [5:0]  shift_r, shift_nxt;
  logic [31:0] pending_r, pending_nxt;
  logic        seen_r, seen_nxt;

  logic [31:0] vlq_val;
  logic [5:0]  shift_adv;
  logic        vlq_done;

  // one vlq byte folded into the accumulator; bits past 32 fall off
  always_comb begin
    vlq_val = accum_r;
    if (shift_r < ltpr_pkg::VLQ_SHIFT_LIMIT) begin
      vlq_val = accum_r | (32'(data_byte & ltpr_pkg::VLQ_PAYLOAD_MASK) << shift_r[4:0]);
    end
    shift_adv = (shift_r + ltpr_pkg::VLQ_SHIFT_STEP > ltpr_pkg::VLQ_SHIFT_MAX) ?
                ltpr_pkg::VLQ_SHIFT_MAX : shift_r + ltpr_pkg::VLQ_SHIFT_STEP;
    vlq_done = !data_byte[7];
  end

  always_comb begin
    phase_nxt   = phase_r;
    accum_nxt   = accum_r;
    shift_nxt   = shift_r;
    pending_nxt = pending_r;
    seen_nxt    = seen_r;
    cmd_push    = 1'b0;
    cmd.kind    = ltpr_pkg::CMD_END;
    cmd.a       = '0;
    cmd.b       = '0;
    if (take) begin
      case (op)
        ltpr_pkg::OP_START: begin
          cmd_push    = 1'b1;
          cmd.kind    = ltpr_pkg::CMD_START;
          cmd.a       = target_pc;
          phase_nxt   = ltpr_pkg::PH_CMD;
          accum_nxt   = '0;
          shift_nxt   = '0;
          pending_nxt = '0;
          seen_nxt    = 1'b0;
        end
        ltpr_pkg::OP_BYTE: begin
          seen_nxt = 1'b1;
          case (phase_r)
            ltpr_pkg::PH_CMD: begin
              accum_nxt = '0;
              shift_nxt = '0;
              if (data_byte == cfg.set_file_code) begin
                phase_nxt = ltpr_pkg::PH_FILE;
              end else if (data_byte == cfg.extended_step_code) begin
                phase_nxt = ltpr_pkg::PH_XPC;
              end else if (data_byte != cfg.prologue_end_code) begin
                cmd_push = 1'b1;
                cmd.kind = ltpr_pkg::CMD_STEP;
                cmd.a    = 32'(data_byte);
                cmd.b    = 32'd1;
              end
            end
            ltpr_pkg::PH_FILE: begin
              accum_nxt = vlq_val;
              shift_nxt = shift_adv;
              if (vlq_done) begin
                cmd_push  = 1'b1;
                cmd.kind  = ltpr_pkg::CMD_SET_FILE;
                cmd.a     = vlq_val;
                phase_nxt = ltpr_pkg::PH_CMD;
              end
            end
            ltpr_pkg::PH_XPC: begin
              accum_nxt = vlq_val;
              shift_nxt = shift_adv;
              if (vlq_done) begin
                pending_nxt = vlq_val;
                accum_nxt   = '0;
                shift_nxt   = '0;
                phase_nxt   = ltpr_pkg::PH_XLINE;
              end
            end
            default: begin
              accum_nxt = vlq_val;
              shift_nxt = shift_adv;
              if (vlq_done) begin
                cmd_push  = 1'b1;
                cmd.kind  = ltpr_pkg::CMD_STEP;
                cmd.a     = pending_r;
                cmd.b     = ltpr_pkg::unzigzag(vlq_val);
                phase_nxt = ltpr_pkg::PH_CMD;
              end
            end
          endcase
        end
        ltpr_pkg::OP_END: begin
          cmd_push  = 1'b1;
          phase_nxt = ltpr_pkg::PH_CMD;
          if (!seen_r) begin
            cmd.kind = ltpr_pkg::CMD_END_EMPTY;
          end else if (phase_r == ltpr_pkg::PH_XPC) begin
            // partial pc delta, no line change
            cmd.kind = ltpr_pkg::CMD_END_STEP;
            cmd.a    = accum_r;
          end else if (phase_r == ltpr_pkg::PH_XLINE) begin
            cmd.kind = ltpr_pkg::CMD_END_STEP;
            cmd.a    = pending_r;
            cmd.b    = ltpr_pkg::unzigzag(accum_r);
          end else begin
            // a partial file index cannot change the held result
            cmd.kind = ltpr_pkg::CMD_END;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ltpr_pkg::PH_CMD;
      seen_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      seen_r  <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    accum_r   <= accum_nxt;
    shift_r   <= shift_nxt;
    pending_r <= pending_nxt;
  end

endmodule

// ===== hw/rtl/ltpr_back.sv =====
// ltpr_back: walks pc/line/file state per command and forms results
// depends on ltpr_pkg
module ltpr_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cmd_valid,
  input  ltpr_pkg::cmd_t   cmd,
  input  logic [15:0]      known_files,
  input  logic             res_full,
  output logic             cmd_pop,
  output logic             res_push,
  output ltpr_pkg::res_t   res
);
  logic [31:0] goal_r, goal_nxt;
  logic [31:0] pc_r, pc_nxt;
  logic [31:0] line_r, line_nxt;
  logic [31:0] file_r, file_nxt;
  logic [15:0] hfile_r, hfile_nxt;
  logic [31:0] hline_r, hline_nxt;
  logic        hunk_r, hunk_nxt;
  logic        done_r, done_nxt;

  logic [32:0] pc_sum;
  logic        covers;
  logic        file_known;
  logic [15:0] file_sat;
  logic [31:0] line_step;

  assign cmd_pop    = cmd_valid && !res_full;
  assign pc_sum     = {1'b0, pc_r} + {1'b0, cmd.a};
  assign covers     = pc_sum > {1'b0, goal_r};
  assign file_known = file_r < {16'd0, known_files};
  assign file_sat   = (file_r[31:16] != '0) ? 16'hFFFF : file_r[15:0];
  assign line_step  = line_r + cmd.b;

  always_comb begin
    goal_nxt  = goal_r;
    pc_nxt    = pc_r;
    line_nxt  = line_r;
    file_nxt  = file_r;
    hfile_nxt = hfile_r;
    hline_nxt = hline_r;
    hunk_nxt  = hunk_r;
    done_nxt  = done_r;
    res_push  = 1'b0;
    res.status       = ltpr_pkg::ST_ENDED;
    res.file_idx     = hfile_r;
    res.unknown_file = hunk_r;
    res.line_number  = hline_r;
    if (cmd_pop) begin
      if (cmd.kind == ltpr_pkg::CMD_START) begin
        goal_nxt  = cmd.a;
        pc_nxt    = '0;
        line_nxt  = 32'd1;
        file_nxt  = '0;
        hfile_nxt = '0;
        hline_nxt = 32'd1;
        hunk_nxt  = (known_files == '0);
        done_nxt  = 1'b0;
      end else if (!done_r) begin
        case (cmd.kind)
          ltpr_pkg::CMD_SET_FILE: begin
            file_nxt = cmd.a;
          end
          ltpr_pkg::CMD_STEP, ltpr_pkg::CMD_END_STEP: begin
            if (covers) begin
              res_push         = 1'b1;
              done_nxt         = 1'b1;
              res.status       = ltpr_pkg::ST_FOUND;
              res.file_idx     = file_sat;
              res.unknown_file = !file_known;
              res.line_number  = line_r;
            end else begin
              pc_nxt   = pc_sum[31:0];
              line_nxt = line_step;
              if (file_known) begin
                hfile_nxt = file_r[15:0];
                hline_nxt = line_step;
                hunk_nxt  = 1'b0;
              end
              if (cmd.kind == ltpr_pkg::CMD_END_STEP) begin
                res_push         = 1'b1;
                done_nxt         = 1'b1;
                res.file_idx     = hfile_nxt;
                res.unknown_file = hunk_nxt;
                res.line_number  = hline_nxt;
              end
            end
          end
          ltpr_pkg::CMD_END: begin
            res_push = 1'b1;
            done_nxt = 1'b1;
          end
          ltpr_pkg::CMD_END_EMPTY: begin
            res_push         = 1'b1;
            done_nxt         = 1'b1;
            res.status       = ltpr_pkg::ST_EMPTY;
            res.file_idx     = '0;
            res.unknown_file = 1'b0;
            res.line_number  = '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b1;
    end else begin
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    goal_r  <= goal_nxt;
    pc_r    <= pc_nxt;
    line_r  <= line_nxt;
    file_r  <= file_nxt;
    hfile_r <= hfile_nxt;
    hline_r <= hline_nxt;
    hunk_r  <= hunk_nxt;
  end

endmodule

// ===== hw/rtl/line_table_pc_resolver.sv =====
// line_table_pc_resolver: top level of the line table pc resolver
// depends on ltpr_pkg, ltpr_fifo, ltpr_front, ltpr_back
//
// Resolves a target pc to a source file index and line by walking an encoded
// line table one byte per word. Push a start word (op 0) with the target pc,
// then the table bytes (op 1), then an end word (op 2); at most one result word
// comes out per query, either when a step covers the target or at the end word.
// Throughput is one input word per clock while in_full is low: the front
// decoder classifies each byte in the cycle it is accepted, the walker
// consumes one command per clock from a small command queue while the result
// queue is not full, and its result words go through the result queue, whose
// head drives the out_ ports. in_full rises only when the command queue is
// full, which happens only while the result queue is backed up by a consumer
// that does not pop. Configuration writes are always taken (cfg_ready is tied
// high) and must only be issued while the block is idle.
module line_table_pc_resolver #(
  parameter int CMD_DEPTH = ltpr_pkg::CMD_DEPTH_DEF,
  parameter int RES_DEPTH = ltpr_pkg::RES_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // input word channel
  input  logic               in_push,
  output logic               in_full,
  input  logic [1:0]         in_op,
  input  logic [31:0]        in_target_pc,
  input  logic [7:0]         in_data_byte,
  // result word channel
  output logic               out_empty,
  input  logic               out_pop,
  output logic [1:0]         out_status,
  output logic [15:0]        out_file_index,
  output logic               out_unknown_file,
  output logic signed [31:0] out_line_number,
  // configuration writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  ltpr_pkg::cfg_t cfg_r, cfg_nxt;

  logic           in_take;
  logic           fcmd_push;
  ltpr_pkg::cmd_t fcmd;
  logic [$bits(ltpr_pkg::cmd_t)-1:0] cmd_q;
  logic           cmd_empty, cmd_full, cmd_pop;
  logic           res_push, res_full;
  ltpr_pkg::res_t bres;
  logic [$bits(ltpr_pkg::res_t)-1:0] res_q;
  ltpr_pkg::res_t res_head;

  // configuration registers, written by index
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        ltpr_pkg::REG_SET_FILE:   cfg_nxt.set_file_code      = cfg_data[7:0];
        ltpr_pkg::REG_EXT_STEP:   cfg_nxt.extended_step_code = cfg_data[7:0];
        ltpr_pkg::REG_PROLOGUE:   cfg_nxt.prologue_end_code  = cfg_data[7:0];
        ltpr_pkg::REG_FILE_COUNT: cfg_nxt.known_files        = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.set_file_code      <= ltpr_pkg::RST_SET_FILE;
      cfg_r.extended_step_code <= ltpr_pkg::RST_EXT_STEP;
      cfg_r.prologue_end_code  <= ltpr_pkg::RST_PROLOGUE;
      cfg_r.known_files        <= ltpr_pkg::RST_FILE_COUNT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front: every accepted word yields at most one command
  assign in_full = cmd_full;
  assign in_take = in_push && !cmd_full;

  ltpr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (in_take),
    .op        (in_op),
    .target_pc (in_target_pc),
    .data_byte (in_data_byte),
    .cfg       (cfg_r),
    .cmd_push  (fcmd_push),
    .cmd       (fcmd)
  );

  // command queue decouples decoder from walker
  ltpr_fifo #(
    .WIDTH ($bits(ltpr_pkg::cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fcmd_push),
    .wdata (fcmd),
    .pop   (cmd_pop),
    .rdata (cmd_q),
    .empty (cmd_empty),
    .full  (cmd_full)
  );

  // back: pc/line walk and range test
  ltpr_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (!cmd_empty),
    .cmd         (ltpr_pkg::cmd_t'(cmd_q)),
    .known_files (cfg_r.known_files),
    .res_full    (res_full),
    .cmd_pop     (cmd_pop),
    .res_push    (res_push),
    .res         (bres)
  );

  // result queue, head word drives the out_ ports
  ltpr_fifo #(
    .WIDTH ($bits(ltpr_pkg::res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (bres),
    .pop   (out_pop),
    .rdata (res_q),
    .empty (out_empty),
    .full  (res_full)
  );

  assign res_head         = ltpr_pkg::res_t'(res_q);
  assign out_status       = res_head.status;
  assign out_file_index   = res_head.file_idx;
  assign out_unknown_file = res_head.unknown_file;
  assign out_line_number  = res_head.line_number;

endmodule

// ===== hw/rtl/ltpr_checker.sv =====
// ltpr_checker: port-level checks for line_table_pc_resolver, bound to it
// depends on ltpr_pkg
module ltpr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_empty,
  input logic               out_pop,
  input logic [1:0]         out_status,
  input logic [15:0]        out_file_index,
  input logic               out_unknown_file,
  input logic signed [31:0] out_line_number
);

  // no result word survives reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  // a waiting word holds until popped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_status) &&
      $stable(out_file_index) && $stable(out_unknown_file) && $stable(out_line_number)))
    else $error("result word changed before pop");

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_status == ltpr_pkg::ST_FOUND || out_status == ltpr_pkg::ST_ENDED ||
      out_status == ltpr_pkg::ST_EMPTY))
    else $error("illegal result status");

  // empty table gives zeroed fields
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status == ltpr_pkg::ST_EMPTY) |->
      (out_file_index == '0 && !out_unknown_file && out_line_number == '0))
    else $error("empty-table result carries nonzero fields");

endmodule

bind line_table_pc_resolver ltpr_checker u_ltpr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_empty        (out_empty),
  .out_pop          (out_pop),
  .out_status       (out_status),
  .out_file_index   (out_file_index),
  .out_unknown_file (out_unknown_file),
  .out_line_number  (out_line_number)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking bench for line_table_pc_resolver, directed table then random queries
// depends on ltpr_pkg and the line_table_pc_resolver rtl only
module tb_top;
  import ltpr_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;   // reserved op, the block drops it
  localparam int PHASE_WORDS   = 110;        // least words sent per register setting
  localparam int SETTLE_CYCLES = 8;          // result latency plus queue slack
  localparam int STALL_LIMIT   = 2000;       // cycles without any handshake
  localparam res_t NO_RES = '0;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_push = 1'b0;
  logic               in_full;
  logic [1:0]         in_op = OP_START;
  logic [31:0]        in_target_pc = '0;
  logic [7:0]         in_data_byte = '0;
  logic               out_empty;
  logic               out_pop = 1'b0;
  logic [1:0]         out_status;
  logic [15:0]        out_file_index;
  logic               out_unknown_file;
  logic signed [31:0] out_line_number;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = REG_SET_FILE;
  logic [15:0]        cfg_data = '0;

  line_table_pc_resolver dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // lookup predictor: shadow registers and walk state
  // ---------------------------------------------------------------------------
  logic [7:0]  sf_code = RST_SET_FILE;
  logic [7:0]  xs_code = RST_EXT_STEP;
  logic [7:0]  pe_code = RST_PROLOGUE;
  logic [15:0] known_files = RST_FILE_COUNT;

  logic [31:0] goal_pc = '0, walk_pc = '0, walk_line = 32'd1, walk_file = '0;
  logic [31:0] vlq_acc = '0, pend_dpc = '0;
  logic [5:0]  vlq_shift = '0;
  phase_t      dec_phase = PH_CMD;
  logic [31:0] held_file = '0, held_line = 32'd1;
  bit          held_unknown = 1'b0, seen_byte = 1'b0, query_done = 1'b1;

  res_t due_lookups[$];   // predicted results, oldest first

  int  words_live = 0, words_sent = 0, lookups_checked = 0, bad_lookups = 0, cfg_sets = 0;
  int  found_cnt = 0, ended_cnt = 0, empty_cnt = 0;
  bit  in_hurry = 1'b0, pop_hurry = 1'b0;

  function automatic res_t lookup_result(input logic [1:0] st, input logic [31:0] file,
                                         input bit unk, input logic [31:0] line);
    res_t r;
    r.status       = st;
    r.file_idx     = (file > 32'd65535) ? 16'hFFFF : file[15:0];
    r.unknown_file = unk;
    r.line_number  = line;
    return r;
  endfunction

  function automatic logic [31:0] zigzag_decode(input logic [31:0] u);
    return u[0] ? ~(u >> 1) : (u >> 1);
  endfunction

  // one walk step over [walk_pc, walk_pc + dpc); range test on the 33-bit sum
  function automatic bit walk_step(input logic [31:0] dpc, input logic [31:0] dline,
                                   output res_t r);
    logic [32:0] span_end;
    span_end = {1'b0, walk_pc} + {1'b0, dpc};
    r = NO_RES;
    if (span_end > {1'b0, goal_pc}) begin
      r = lookup_result(ST_FOUND, walk_file, walk_file >= {16'd0, known_files}, walk_line);
      query_done = 1'b1;
      return 1'b1;
    end
    walk_pc   = walk_pc + dpc;
    walk_line = walk_line + dline;
    // held result only follows known files
    if (walk_file < {16'd0, known_files}) begin
      held_file    = walk_file;
      held_line    = walk_line;
      held_unknown = 1'b0;
    end
    return 1'b0;
  endfunction

  // adds one vlq byte, payload past bit 31 is dropped; 1 when the value is complete
  function automatic bit vlq_add(input logic [7:0] data);
    if (vlq_shift < VLQ_SHIFT_LIMIT) vlq_acc = vlq_acc | (32'(data[6:0]) << vlq_shift);
    if (!data[7]) return 1'b1;
    vlq_shift = (vlq_shift + VLQ_SHIFT_STEP > VLQ_SHIFT_MAX) ? VLQ_SHIFT_MAX
                                                              : vlq_shift + VLQ_SHIFT_STEP;
    return 1'b0;
  endfunction

  // advances the predictor by one accepted word; 1 when a result is due
  function automatic bit resolve_word(input logic [1:0] op, input logic [31:0] pc,
                                      input logic [7:0] data, output res_t r);
    r = NO_RES;
    if (op == OP_START) begin
      goal_pc = pc; walk_pc = '0; walk_line = 32'd1; walk_file = '0;
      vlq_acc = '0; vlq_shift = '0; dec_phase = PH_CMD; pend_dpc = '0;
      held_file = '0; held_line = 32'd1; held_unknown = (known_files == 16'd0);
      seen_byte = 1'b0; query_done = 1'b0;
      return 1'b0;
    end
    if (op == OP_UNUSED || query_done) return 1'b0;
    if (op == OP_BYTE) begin
      seen_byte = 1'b1;
      case (dec_phase)
        PH_CMD: begin
          vlq_acc = '0; vlq_shift = '0;
          // set-file wins over extended step, which wins over prologue end
          if (data == sf_code) dec_phase = PH_FILE;
          else if (data == xs_code) dec_phase = PH_XPC;
          else if (data != pe_code) return walk_step(32'(data), 32'd1, r);
        end
        PH_FILE: if (vlq_add(data)) begin
          walk_file = vlq_acc;
          dec_phase = PH_CMD;
        end
        PH_XPC: if (vlq_add(data)) begin
          pend_dpc = vlq_acc;
          vlq_acc = '0; vlq_shift = '0;
          dec_phase = PH_XLINE;
        end
        default: if (vlq_add(data)) begin
          dec_phase = PH_CMD;
          return walk_step(pend_dpc, zigzag_decode(vlq_acc), r);
        end
      endcase
      return 1'b0;
    end
    // end of table
    if (!seen_byte) begin
      query_done = 1'b1;
      r = lookup_result(ST_EMPTY, 32'd0, 1'b0, 32'd0);
      return 1'b1;
    end
    // a partial operand is taken as it stands
    if (dec_phase == PH_FILE) begin
      walk_file = vlq_acc;
    end else if (dec_phase == PH_XPC) begin
      dec_phase = PH_CMD;
      if (walk_step(vlq_acc, 32'd0, r)) return 1'b1;
    end else if (dec_phase == PH_XLINE) begin
      dec_phase = PH_CMD;
      if (walk_step(pend_dpc, zigzag_decode(vlq_acc), r)) return 1'b1;
    end
    dec_phase  = PH_CMD;
    query_done = 1'b1;
    r = lookup_result(ST_ENDED, held_file, held_unknown, held_line);
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------
  task automatic push_word(input logic [1:0] op, input logic [31:0] pc, input logic [7:0] data,
                           output bit has, output res_t r);
    int gap;
    gap = in_hurry ? 0 : $urandom_range(0, 8);
    if ($urandom_range(0, 47) == 0) in_hurry = !in_hurry;
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push      <= 1'b1;
    in_op        <= op;
    in_target_pc <= pc;
    in_data_byte <= data;
    @(posedge clk);
    while (in_full) @(posedge clk);
    words_sent++;
    // words the block just drops do not count
    if (op == OP_START || (op != OP_UNUSED && !query_done)) words_live++;
    has = resolve_word(op, pc, data, r);
  endtask

  task automatic send(input logic [1:0] op, input logic [31:0] pc, input logic [7:0] data);
    bit   has;
    res_t r;
    push_word(op, pc, data, has, r);
    if (has) due_lookups = {due_lookups, r};
  endtask

  // vlq encoder: sometimes over-long with junk above bit 31, sometimes cut short
  task automatic push_vlq(input logic [31:0] v, inout bit cut);
    logic [55:0] wide;
    int groups, stop, i;
    groups = 1;
    while (groups < 5 && (v >> (7 * groups)) != 0) groups++;
    wide = {24'd0, v};
    if ($urandom_range(0, 7) == 0) begin
      groups = $urandom_range(5, 8);
      wide[55:32] = 24'($urandom);
    end
    stop = groups;
    if ($urandom_range(0, 11) == 0) begin
      stop = $urandom_range(0, groups - 1);
      cut = 1'b1;
    end
    for (i = 0; i < stop; i++) send(OP_BYTE, $urandom, {(i < groups - 1), wide[7 * i +: 7]});
  endtask

  // ---------------------------------------------------------------------------
  // configuration, only while idle
  // ---------------------------------------------------------------------------
  task automatic settle();
    in_push <= 1'b0;
    while (due_lookups.size() != 0) @(posedge clk);
    // words with no result may still sit in the command queue
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_SET_FILE:   sf_code     = data[7:0];
      REG_EXT_STEP:   xs_code     = data[7:0];
      REG_PROLOGUE:   pe_code     = data[7:0];
      REG_FILE_COUNT: known_files = data;
      default: begin
      end
    endcase
  endtask

  task automatic program_regs(input logic [7:0] sf, xs, pe, input logic [15:0] fc);
    cfg_write(REG_SET_FILE, {8'd0, sf});
    cfg_write(REG_EXT_STEP, {8'd0, xs});
    cfg_write(REG_PROLOGUE, {8'd0, pe});
    cfg_write(REG_FILE_COUNT, fc);
    cfg_valid <= 1'b0;
    cfg_sets++;
  endtask

  // random queries under one register setting: mostly well-formed walks
  task automatic run_phase(input logic [7:0] sf, xs, pe, input logic [15:0] fc);
    int first, n, k, kind;
    bit cut;
    logic [7:0] b;
    logic [31:0] v;
    settle();
    program_regs(sf, xs, pe, fc);
    first = words_sent;
    while (words_sent - first < PHASE_WORDS) begin
      case ($urandom_range(0, 7))
        0:       v = 32'd0;
        1:       v = $urandom;
        2:       v = 32'hFFFF_FFFF - $urandom_range(0, 300);
        default: v = $urandom_range(0, 800);
      endcase
      send(OP_START, v, 8'($urandom));
      n = $urandom_range(0, 14);
      cut = 1'b0;
      for (k = 0; k < n && !cut; k++) begin
        kind = $urandom_range(0, 11);
        if (kind <= 4) begin
          // plain step, kept off the command codes
          do begin
            b = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 40)) : 8'($urandom);
          end while (b == sf_code || b == xs_code || b == pe_code);
          send(OP_BYTE, $urandom, b);
        end else if (kind <= 6) begin
          send(OP_BYTE, $urandom, sf_code);
          case ($urandom_range(0, 5))
            0:       v = $urandom;
            1:       v = $urandom_range(65530, 65545);
            default: v = $urandom_range(0, int'(known_files) + 2);
          endcase
          push_vlq(v, cut);
        end else if (kind <= 9) begin
          send(OP_BYTE, $urandom, xs_code);
          v = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 200);
          push_vlq(v, cut);
          if (!cut) begin
            v = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 40);
            push_vlq(v, cut);
          end
        end else if (kind == 10) begin
          send(OP_BYTE, $urandom, pe_code);
        end else begin
          // noise: any op, any content
          send(2'($urandom), $urandom, 8'($urandom));
        end
      end
      // a missing end word leaves the query to be dropped by the next start
      if (cut || $urandom_range(0, 9) != 0) send(OP_END, $urandom, 8'($urandom));
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stalls, compare against the oldest prediction
  // ---------------------------------------------------------------------------
  function automatic bit note_bad();
    bad_lookups++;
    return bad_lookups <= 10;
  endfunction

  initial begin
    int   gap;
    res_t want, got;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = pop_hurry ? 0 : $urandom_range(0, 8);
      if ($urandom_range(0, 31) == 0) pop_hurry = !pop_hurry;
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_pop <= 1'b1;
      @(posedge clk);
      while (out_empty) @(posedge clk);
      got = '{out_status, out_file_index, out_unknown_file, out_line_number};
      if (due_lookups.size() == 0) begin
        if (note_bad())
          $display("unexpected result word: status %0d file %0d unk %0d line %0d",
                   got.status, got.file_idx, got.unknown_file, got.line_number);
      end else begin
        want = due_lookups.pop_front();
        lookups_checked++;
        if (got.status != want.status || got.file_idx != want.file_idx ||
            got.unknown_file != want.unknown_file || got.line_number != want.line_number) begin
          if (note_bad())
            $display("result %0d: got st %0d file %0d unk %0d line %0d, want st %0d file %0d unk %0d line %0d",
                     lookups_checked, got.status, got.file_idx, got.unknown_file,
                     got.line_number, want.status, want.file_idx, want.unknown_file,
                     want.line_number);
        end
        case (got.status)
          ST_FOUND: found_cnt++;
          ST_ENDED: ended_cnt++;
          default:  empty_cnt++;
        endcase
      end
    end
  end

  // watchdog: any handshake resets the count
  int stall_cycles = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, due_lookups.size());
        $display("[line_table_pc_resolver] ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // directed words under reset register values; fixed expectations where obvious
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] pc;
    logic [7:0]  data;
    logic        pinned;   // want holds the expected result word
    res_t        want;
  } dir_row_t;

  dir_row_t dir_rows [25] = '{
    '{OP_BYTE,    32'h0,         8'h05, 1'b0, NO_RES},  // no query open
    '{OP_END,     32'h0,         8'h00, 1'b0, NO_RES},  // no query open
    '{OP_UNUSED,  32'hFFFF_FFFF, 8'hFF, 1'b0, NO_RES},  // reserved op
    '{OP_START,   32'h1234,      8'h00, 1'b0, NO_RES},
    '{OP_START,   32'h0,         8'h00, 1'b0, NO_RES},  // restart drops the open query
    '{OP_END,     32'h0,         8'h00, 1'b1, '{ST_EMPTY, 16'd0, 1'b0, 32'sd0}},
    '{OP_START,   32'hFFFF_FFFF, 8'h00, 1'b0, NO_RES},
    '{OP_BYTE,    32'h0,         8'h00, 1'b0, NO_RES},  // zero-length step, line 2
    '{OP_BYTE,    32'h0,  RST_PROLOGUE, 1'b0, NO_RES},
    '{OP_BYTE,    32'h0,  RST_SET_FILE, 1'b0, NO_RES},
    '{OP_BYTE,    32'h0,         8'h83, 1'b0, NO_RES},
    '{OP_BYTE,    32'h0,         8'h01, 1'b0, NO_RES},  // file 131
    '{OP_BYTE,    32'h0,  RST_EXT_STEP, 1'b0, NO_RES},
    '{OP_BYTE,    32'h0,         8'hFF, 1'b0, NO_RES},  // six-byte pc delta, top bits dropped
    '{OP_BYTE,    32'h0,         8'hFF, 1'b0, NO_RES},
    '{OP_BYTE,    32'h0,         8'hFF, 1'b0, NO_RES},
    '{OP_BYTE,    32'h0,         8'hFF, 1'b0, NO_RES},
    '{OP_BYTE,    32'h0,         8'hFF, 1'b0, NO_RES},
    '{OP_BYTE,    32'h0,         8'h7F, 1'b0, NO_RES},
    '{OP_BYTE,    32'h0,         8'h03, 1'b0, NO_RES},  // line delta -2, pc at max
    '{OP_BYTE,    32'h0,         8'h01, 1'b1, '{ST_FOUND, 16'd131, 1'b1, 32'sd0}},
    '{OP_START,   32'd5,         8'h00, 1'b0, NO_RES},
    '{OP_BYTE,    32'h0,  RST_EXT_STEP, 1'b0, NO_RES},
    '{OP_BYTE,    32'h0,         8'h02, 1'b0, NO_RES},
    '{OP_END,     32'h0,         8'h00, 1'b1, '{ST_ENDED, 16'd0, 1'b1, 32'sd1}}  // mid line delta
  };

  initial begin
    int   i;
    bit   has;
    res_t r;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < 25; i++) begin
      push_word(dir_rows[i].op, dir_rows[i].pc, dir_rows[i].data, has, r);
      if (dir_rows[i].pinned) due_lookups = {due_lookups, dir_rows[i].want};
      else if (has) due_lookups = {due_lookups, r};
    end

    // register sweep: defaults with known files, all codes equal, top values, set-file
    // sharing the extended code, extended sharing the prologue code, random codes, reset codes
    run_phase(RST_SET_FILE, RST_EXT_STEP, RST_PROLOGUE, 16'd4);
    run_phase(8'h00, 8'h00, 8'h00, 16'd0);
    run_phase(8'h80, 8'h81, 8'h7F, 16'hFFFF);
    run_phase(8'd7, 8'd7, 8'd9, 16'd2);
    run_phase(8'd3, 8'd200, 8'd200, 16'd1);
    run_phase(8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom_range(0, 12)));
    run_phase(8'hFF, 8'hFE, 8'hFD, 16'd0);

    settle();
    if (due_lookups.size() != 0) begin
      bad_lookups += due_lookups.size();
      $display("%0d predicted results never came out", due_lookups.size());
    end

    $display("sent %0d words (%0d live) over %0d register settings, %0d mismatches",
             words_sent, words_live, cfg_sets, bad_lookups);
    $display("checked %0d results: %0d in range, %0d table ended, %0d empty table",
             lookups_checked, found_cnt, ended_cnt, empty_cnt);
    if (bad_lookups == 0) begin
      $display("[line_table_pc_resolver] OK");
    end else begin
      $display("[line_table_pc_resolver] ERROR");
    end
    $finish;
  end

endmodule
